### rtl/esc_pkg.sv
// ---------------------------------------------------------------------------
// esc_pkg: shared types and constants of the end-spin correlation reducer
// Payload structs, queue entry, back-end states and fixed-point helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int SPIN_W  = 4;
  localparam int AMP_W   = 16;
  localparam int SQ_W    = 31;
  localparam int NRM_W   = 23;
  localparam int NRM_LSB = 9;
  localparam int ACC_W   = 48;
  localparam int ACC_N   = 4;
  localparam int CLP_W   = 33;
  localparam int MUL_W   = 2 * CLP_W;
  localparam int PROD_W  = 64;
  localparam int DIFF_W  = 42;
  localparam int CORR_W  = 32;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int STEP_W  = 3;

  localparam logic [SPIN_W-1:0] SPIN_RESET = 4'd4;

  // accumulator slots
  localparam logic [1:0] ACC_ZZ    = 2'd0;
  localparam logic [1:0] ACC_LSQ   = 2'd1;
  localparam logic [1:0] ACC_RSQ   = 2'd2;
  localparam logic [1:0] ACC_CROSS = 2'd3;

  // sequencer steps of the back end
  localparam logic [STEP_W-1:0] STEP_CLAMP    = 3'd0;
  localparam logic [STEP_W-1:0] VEC_MUL_ZZ    = 3'd1;
  localparam logic [STEP_W-1:0] VEC_MUL_LSQ   = 3'd2;
  localparam logic [STEP_W-1:0] VEC_MUL_RSQ   = 3'd3;
  localparam logic [STEP_W-1:0] VEC_MUL_CROSS = 3'd4;
  localparam logic [STEP_W-1:0] VEC_DONE      = 3'd5;
  localparam logic [STEP_W-1:0] SET_LSRS      = 3'd1;
  localparam logic [STEP_W-1:0] SET_CRCR      = 3'd2;
  localparam logic [STEP_W-1:0] SET_DIFF      = 3'd3;
  localparam logic [STEP_W-1:0] SET_CSQ       = 3'd4;
  localparam logic [STEP_W-1:0] SET_DONE      = 3'd5;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] LIM_HI  = 48'sh0000_8000_0000;
  localparam logic signed [ACC_W-1:0] LIM_LO  = 48'shFFFF_8000_0000;
  localparam logic signed [CLP_W-1:0] CLP_HI  = 33'sh0_8000_0000;
  localparam logic signed [CLP_W-1:0] CLP_LO  = 33'sh1_8000_0000;

  typedef struct packed {
    logic signed [AMP_W-1:0] amp_real;
    logic signed [AMP_W-1:0] amp_imag;
  } esc_in_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic [CORR_W-1:0]        correlation_square;
  } esc_out_t;

  typedef struct packed {
    logic [SQ_W-1:0]   sq_re;
    logic [SQ_W-1:0]   sq_im;
    logic              left_pos;
    logic              right_pos;
    logic              last_entry;
    logic              last_vector;
    logic [SPIN_W-1:0] spins;
  } esc_item_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_VEC,
    ST_SET,
    ST_OUT
  } esc_state_t;

  // clamp to [-2^31, 2^31]
  function automatic logic signed [CLP_W-1:0] clamp_acc(input logic signed [ACC_W-1:0] x);
    logic signed [CLP_W-1:0] r;
    if (x > LIM_HI) begin
      r = CLP_HI;
    end else if (x < LIM_LO) begin
      r = CLP_LO;
    end else begin
      r = x[CLP_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic [ACC_W:0]           s;
    logic signed [ACC_W-1:0]  r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/esc_front.sv
// ---------------------------------------------------------------------------
// esc_front: input stage of the end-spin correlation reducer
// Holds the spin count, tracks entry and vector position, tags each
// amplitude with its spin signs and squares its parts for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_front #(
  parameter int MAX_SPINS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  esc_pkg::esc_in_t            in_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [esc_pkg::SPIN_W-1:0]  cfg_data,
  output logic                        push,
  output esc_pkg::esc_item_t          push_item,
  input  logic                        q_full
);
  import esc_pkg::*;

  localparam int IDX_W = MAX_SPINS;
  localparam int CNT_W = MAX_SPINS + 1;
  localparam logic [SPIN_W-1:0] SPIN_MAX = SPIN_W'(MAX_SPINS);

  logic [SPIN_W-1:0] spin_r;
  logic [SPIN_W-1:0] spins;
  logic [CNT_W-1:0]  dim;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  entry_inc;
  logic [CNT_W-1:0]  vector_inc;
  logic [IDX_W-1:0]  entry_idx_r;
  logic [IDX_W-1:0]  vector_idx_r;
  logic              last_entry;
  logic              last_vector;
  logic              accept;

  logic              stg_v_r;
  esc_in_t           stg_amp_r;
  logic              stg_left_r;
  logic              stg_right_r;
  logic              stg_last_e_r;
  logic              stg_last_v_r;
  logic [SPIN_W-1:0] stg_spins_r;

  logic signed [2*AMP_W-1:0] re_sq;
  logic signed [2*AMP_W-1:0] im_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r <= SPIN_RESET;
    end else if (cfg_valid) begin
      spin_r <= cfg_data;
    end
  end

  always_comb begin
    if (spin_r == '0) begin
      spins = SPIN_W'(1);
    end else if (spin_r > SPIN_MAX) begin
      spins = SPIN_MAX;
    end else begin
      spins = spin_r;
    end
  end

  assign dim         = CNT_W'(1) << spins;
  assign half        = dim >> 1;
  assign entry_inc   = {1'b0, entry_idx_r} + 1'b1;
  assign vector_inc  = {1'b0, vector_idx_r} + 1'b1;
  assign last_entry  = (entry_inc >= dim);
  assign last_vector = (vector_inc >= dim);

  // hold the input while the staged item cannot enter the queue
  assign in_stall = stg_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = stg_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r      <= 1'b0;
      entry_idx_r  <= '0;
      vector_idx_r <= '0;
    end else begin
      if (accept) begin
        stg_v_r <= 1'b1;
        if (last_entry) begin
          entry_idx_r  <= '0;
          vector_idx_r <= last_vector ? '0 : vector_inc[IDX_W-1:0];
        end else begin
          entry_idx_r <= entry_inc[IDX_W-1:0];
        end
      end else if (push) begin
        stg_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_amp_r    <= in_data;
      stg_left_r   <= ({1'b0, entry_idx_r} >= half);
      stg_right_r  <= entry_idx_r[0];
      stg_last_e_r <= last_entry;
      stg_last_v_r <= last_entry && last_vector;
      stg_spins_r  <= spins;
    end
  end

  assign re_sq = stg_amp_r.amp_real * stg_amp_r.amp_real;
  assign im_sq = stg_amp_r.amp_imag * stg_amp_r.amp_imag;

  always_comb begin
    push_item.sq_re       = re_sq[SQ_W-1:0];
    push_item.sq_im       = im_sq[SQ_W-1:0];
    push_item.left_pos    = stg_left_r;
    push_item.right_pos   = stg_right_r;
    push_item.last_entry  = stg_last_e_r;
    push_item.last_vector = stg_last_v_r;
    push_item.spins       = stg_spins_r;
  end

endmodule

`default_nettype wire

### rtl/esc_queue.sv
// ---------------------------------------------------------------------------
// esc_queue: decoupling queue between front and back end
// Small register FIFO of classified items.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  esc_pkg::esc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output esc_pkg::esc_item_t pop_item,
  output logic               pop_valid
);
  import esc_pkg::*;

  esc_item_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     count_r;

  assign full      = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a write");
`endif

endmodule

`default_nettype wire

### rtl/esc_back.sv
// ---------------------------------------------------------------------------
// esc_back: accumulation and finishing sequencer
// Sums signed magnitudes per vector, folds each vector into the set
// accumulators and forms the correlation through one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_back #(
  parameter int MAX_SPINS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  esc_pkg::esc_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output esc_pkg::esc_out_t  out_data
);
  import esc_pkg::*;

  // up to 2^MAX_SPINS magnitudes of at most 2^22 each, plus sign
  localparam int SUM_W = MAX_SPINS + 24;

  esc_state_t              state_r;
  esc_state_t              state_nxt;
  logic [STEP_W-1:0]       step_r;
  logic [STEP_W-1:0]       step_nxt;

  logic signed [SUM_W-1:0] left_sum_r;
  logic signed [SUM_W-1:0] right_sum_r;
  logic signed [SUM_W-1:0] prod_sum_r;
  logic signed [ACC_W-1:0] acc_r [ACC_N];
  logic signed [CLP_W-1:0] clp_r [ACC_N];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [CORR_W-1:0] corr_r;
  logic                     last_vec_r;
  logic [SPIN_W-1:0]        spins_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  esc_out_t                 out_data_r;

  logic [SQ_W:0]            mag_sum;
  logic [SUM_W-1:0]         nrm;
  logic                     out_load;
  logic                     acc_en;
  logic [1:0]               acc_idx;
  logic                     mul_en;
  logic signed [CLP_W-1:0]  mul_a;
  logic signed [CLP_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]  mul_full;
  logic signed [DIFF_W-1:0] zz4;
  logic signed [DIFF_W-1:0] term;
  logic signed [DIFF_W-1:0] diff_fin;
  logic signed [CORR_W-1:0] corr_sat;
  logic [CORR_W-1:0]        sq_sat;

  // |amp|^2 in Q.21
  assign mag_sum = {1'b0, q_item.sq_re} + {1'b0, q_item.sq_im};
  assign nrm     = SUM_W'(mag_sum[SQ_W:NRM_LSB]);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    acc_en    = 1'b0;
    unique case (state_r)
      ST_ACC: begin
        q_pop = q_valid;
        if (q_valid && q_item.last_entry) begin
          state_nxt = ST_VEC;
          step_nxt  = STEP_CLAMP;
        end
      end
      ST_VEC: begin
        acc_en = (step_r >= VEC_MUL_LSQ);
        if (step_r == VEC_DONE) begin
          state_nxt = last_vec_r ? ST_SET : ST_ACC;
          step_nxt  = STEP_CLAMP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SET: begin
        if (step_r == SET_DONE) begin
          state_nxt = ST_OUT;
          step_nxt  = STEP_CLAMP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_OUT: begin
        out_load = !out_valid_r || !out_stall;
        if (out_load) begin
          state_nxt = ST_ACC;
        end
      end
      default: ;
    endcase
  end

  // product issued one step earlier lands in slot step-2
  assign acc_idx = 2'(step_r - VEC_MUL_LSQ);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = clp_r[ACC_ZZ];
    mul_b  = clp_r[ACC_ZZ];
    if (state_r == ST_VEC) begin
      unique case (step_r)
        VEC_MUL_ZZ: begin
          mul_en = 1'b1;
        end
        VEC_MUL_LSQ: begin
          mul_en = 1'b1;
          mul_a  = clp_r[ACC_LSQ];
          mul_b  = clp_r[ACC_LSQ];
        end
        VEC_MUL_RSQ: begin
          mul_en = 1'b1;
          mul_a  = clp_r[ACC_RSQ];
          mul_b  = clp_r[ACC_RSQ];
        end
        VEC_MUL_CROSS: begin
          mul_en = 1'b1;
          mul_a  = clp_r[ACC_LSQ];
          mul_b  = clp_r[ACC_RSQ];
        end
        default: ;
      endcase
    end else if (state_r == ST_SET) begin
      unique case (step_r)
        SET_LSRS: begin
          mul_en = 1'b1;
          mul_a  = clp_r[ACC_LSQ];
          mul_b  = clp_r[ACC_RSQ];
        end
        SET_CRCR: begin
          mul_en = 1'b1;
          mul_a  = clp_r[ACC_CROSS];
          mul_b  = clp_r[ACC_CROSS];
        end
        SET_CSQ: begin
          mul_en = 1'b1;
          mul_a  = {corr_r[CORR_W-1], corr_r};
          mul_b  = {corr_r[CORR_W-1], corr_r};
        end
        default: ;
      endcase
    end
  end

  assign mul_full = mul_a * mul_b;

  assign zz4      = DIFF_W'(clp_r[ACC_ZZ]) <<< 2;
  assign term     = DIFF_W'($signed(prod_r[PROD_W-1:24]));
  assign diff_fin = diff_r - term;

  always_comb begin
    if (!diff_fin[DIFF_W-1] && (|diff_fin[DIFF_W-2:CORR_W-1])) begin
      corr_sat = {1'b0, {(CORR_W-1){1'b1}}};
    end else if (diff_fin[DIFF_W-1] && !(&diff_fin[DIFF_W-2:CORR_W-1])) begin
      corr_sat = {1'b1, {(CORR_W-1){1'b0}}};
    end else begin
      corr_sat = diff_fin[CORR_W-1:0];
    end
  end

  // corr^2 is never negative; drop Q.28 fraction and clip
  assign sq_sat = (|prod_r[PROD_W-1:60]) ? {CORR_W{1'b1}} : prod_r[59:28];

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      step_r      <= STEP_CLAMP;
      left_sum_r  <= '0;
      right_sum_r <= '0;
      prod_sum_r  <= '0;
      acc_r       <= '{default: '0};
      last_vec_r  <= 1'b0;
      spins_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        left_sum_r  <= q_item.left_pos  ? left_sum_r + nrm  : left_sum_r - nrm;
        right_sum_r <= q_item.right_pos ? right_sum_r + nrm : right_sum_r - nrm;
        prod_sum_r  <= (q_item.left_pos == q_item.right_pos) ? prod_sum_r + nrm
                                                             : prod_sum_r - nrm;
        if (q_item.last_entry) begin
          last_vec_r <= q_item.last_vector;
          spins_r    <= q_item.spins;
        end
      end
      if (state_r == ST_VEC && step_r == VEC_DONE) begin
        left_sum_r  <= '0;
        right_sum_r <= '0;
        prod_sum_r  <= '0;
      end
      if (acc_en) begin
        acc_r[acc_idx] <= sat_add(acc_r[acc_idx], prod_r[PROD_W-1:16]);
      end
      if (out_load) begin
        acc_r <= '{default: '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_VEC && step_r == STEP_CLAMP) begin
      clp_r[ACC_ZZ]  <= clamp_acc(ACC_W'(prod_sum_r));
      clp_r[ACC_LSQ] <= clamp_acc(ACC_W'(left_sum_r));
      clp_r[ACC_RSQ] <= clamp_acc(ACC_W'(right_sum_r));
    end
    if (state_r == ST_SET && step_r == STEP_CLAMP) begin
      for (int i = 0; i < ACC_N; i++) begin
        clp_r[i] <= clamp_acc(acc_r[i] >>> spins_r);
      end
    end
    if (mul_en) begin
      prod_r <= mul_full[PROD_W-1:0];
    end
    if (state_r == ST_SET && step_r == SET_CRCR) begin
      diff_r <= zz4 - term;
    end
    if (state_r == ST_SET && step_r == SET_DIFF) begin
      corr_r <= corr_sat;
    end
    if (out_load) begin
      out_data_r.correlation        <= corr_r;
      out_data_r.correlation_square <= sq_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result raised outside output state");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_load) |=>
      (acc_r[0] == '0 && acc_r[1] == '0 && acc_r[2] == '0 && acc_r[3] == '0))
    else $error("set accumulators not cleared after result");

  a_vec_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VEC && step_r == VEC_DONE) |=>
      (left_sum_r == '0 && right_sum_r == '0 && prod_sum_r == '0))
    else $error("vector sums not cleared at vector end");
`endif

endmodule

`default_nettype wire

### rtl/end_spin_correlation_reducer_top.sv
// ---------------------------------------------------------------------------
// end_spin_correlation_reducer_top: end-to-end zz correlation reducer
// Streams dim vectors of dim amplitudes and emits one correlation result
// per set.
// ---------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       in_valid / in_stall    esc_in_t: amp_real, amp_imag (Q1.15)
// out      out_valid / out_stall  esc_out_t: correlation, correlation_square
// cfg      cfg_valid / cfg_ready  cfg_data: spin_count (4 bits, always ready)
//
// The back end consumes one amplitude per cycle inside a vector while the
// queue holds items; each vector end runs a clamp, four products on one shared
// 33x33 multiplier and a last accumulate, the front stage and the 4-entry
// queue holding up to 5 items meanwhile. A set end runs its own clamp, product
// and difference steps, then loads the result register when out_stall is low
// or none is held. Reset clears counters, sums, accumulators; spin_count is 4.
// ---------------------------------------------------------------------------
`default_nettype none

module end_spin_correlation_reducer_top #(
  parameter int MAX_SPINS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  esc_pkg::esc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output esc_pkg::esc_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [esc_pkg::SPIN_W-1:0] cfg_data
);
  import esc_pkg::*;

  logic      push;
  esc_item_t push_item;
  logic      q_full;
  logic      q_pop;
  esc_item_t q_item;
  logic      q_valid;

  esc_front #(
    .MAX_SPINS (MAX_SPINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  esc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .pop_valid (q_valid)
  );

  esc_back #(
    .MAX_SPINS (MAX_SPINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
